>>> rtl/core/mwd_pkg.sv
// ----------------------------------------------------------------------------
// mwd_pkg
// Shared types, codes and helpers for the mesh wet/dry element flagger.
// ----------------------------------------------------------------------------
package mwd_pkg;

	localparam int NODE_COUNT_MAX_DEF = 4096;
	localparam int ELEM_COUNT_MAX_DEF = 8192;

	localparam int NODE_W  = 12;
	localparam int ELEM_W  = 13;
	localparam int HEAD_W  = 32;
	localparam int REQ_W   = 2;
	localparam int FLAG_W  = 2;
	localparam int SIGN_W  = 4;
	localparam int IN_DW   = 128;
	localparam int OUT_DW  = 8;
	localparam int CORNERS = 3;

	localparam int SB_POS_NOW  = 0;
	localparam int SB_NEG_NOW  = 1;
	localparam int SB_NEG_PREV = 2;
	localparam int SB_MARK     = 3;

	localparam logic [FLAG_W-1:0] FLAG_WET  = 2'd0;
	localparam logic [FLAG_W-1:0] FLAG_NEAR = 2'd1;
	localparam logic [FLAG_W-1:0] FLAG_DRY  = 2'd2;

	typedef logic [SIGN_W-1:0] sign_t;
	typedef logic [NODE_W-1:0] node_t;

	typedef enum logic [REQ_W-1:0] {
		REQ_NODE  = 2'd0,
		REQ_ELEM  = 2'd1,
		REQ_QUERY = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ELEM,
		ST_READ,
		ST_MARK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic       clr_we;
		logic       elem_rd;
		logic       node_rd;
		logic       acc_clr;
		logic       acc_step;
		logic       mark_we;
		logic [1:0] step;
		logic       finish;
	} ctl_t;

	typedef struct packed {
		logic all_pos;
		logic any_mark;
		logic all_dry;
	} acc_t;

	function automatic sign_t sign_of(logic [HEAD_W-1:0] now, logic [HEAD_W-1:0] prev);
		sign_t s;
		s              = '0;
		s[SB_NEG_NOW]  = now[HEAD_W-1];
		s[SB_POS_NOW]  = !now[HEAD_W-1] && (now != '0);
		s[SB_NEG_PREV] = prev[HEAD_W-1];
		return s;
	endfunction

endpackage

>>> rtl/core/mesh_wet_dry_element_flagger.sv
// ----------------------------------------------------------------------------
// mesh_wet_dry_element_flagger
// Flags triangular mesh elements as wet, near dry or dry from node depths.
// ----------------------------------------------------------------------------
// After reset the block clears its node table, one entry a cycle, and takes
// no request until that is done. A node load writes the node table directly.
// A query first reads its corners from the element table. An element load and
// a query read the three corner entries one after another through the single
// read port of the node table, and an element load then writes its marks
// through the single write port; a load or query with an element number out
// of range skips these steps. Each request returns exactly one result.
module mesh_wet_dry_element_flagger
	import mwd_pkg::*;
#(
	parameter int NODE_COUNT_MAX = NODE_COUNT_MAX_DEF,
	parameter int ELEM_COUNT_MAX = ELEM_COUNT_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// node_index, head_now, head_before, elem_index, corner_a, corner_b, corner_c
	input  logic [IN_DW-1:0]  s_tdata,
	// req_type
	input  logic [REQ_W-1:0]  s_tuser,
	output logic              m_tvalid,
	input  logic              m_tready,
	// wet_dry_flag
	output logic [OUT_DW-1:0] m_tdata
);

	localparam int NAW = (NODE_COUNT_MAX > 1) ? $clog2(NODE_COUNT_MAX) : 1;
	localparam int EAW = (ELEM_COUNT_MAX > 1) ? $clog2(ELEM_COUNT_MAX) : 1;
	localparam logic [31:0] NODE_LIM = 32'(NODE_COUNT_MAX);
	localparam logic [31:0] ELEM_LIM = 32'(ELEM_COUNT_MAX);
	localparam int CRN_W = CORNERS * NODE_W;

	node_t              node_index;
	logic signed [31:0] head_now;
	logic signed [31:0] head_before;
	logic [ELEM_W-1:0]  elem_index;
	node_t              corner_a;
	node_t              corner_b;
	node_t              corner_c;
	req_t               req_type;

	assign node_index  = s_tdata[11:0];
	assign head_now    = s_tdata[43:12];
	assign head_before = s_tdata[75:44];
	assign elem_index  = s_tdata[88:76];
	assign corner_a    = s_tdata[100:89];
	assign corner_b    = s_tdata[112:101];
	assign corner_c    = s_tdata[124:113];
	assign req_type    = req_t'(s_tuser);

	logic accept;
	logic out_free;
	logic node_ok_in;
	logic elem_ok_in;

	assign accept     = s_tvalid && s_tready;
	assign out_free   = !m_tvalid || m_tready;
	assign node_ok_in = 32'(node_index) < NODE_LIM;
	assign elem_ok_in = 32'(elem_index) < ELEM_LIM;

	req_t              req_q;
	logic              elem_ok_q;
	logic [EAW-1:0]    elem_addr_q;
	node_t             corner_q [CORNERS];
	sign_t             sgn_q [CORNERS];
	logic              ok_s1;
	logic              m_tvalid_q;
	logic [FLAG_W-1:0] flag_q;

	logic [NAW+NODE_W-1:0] node_ext;
	logic [EAW+ELEM_W-1:0] elem_ext;
	logic [EAW-1:0]        elem_addr;

	assign node_ext  = (NAW + NODE_W)'(node_index);
	assign elem_ext  = (EAW + ELEM_W)'(elem_index);
	assign elem_addr = elem_ext[EAW-1:0];

	ctl_t           ctl;
	logic [NAW-1:0] clr_addr;

	mwd_ctrl #(
		.NODE_COUNT_MAX(NODE_COUNT_MAX),
		.NAW           (NAW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.req_in    (req_type),
		.elem_ok_in(elem_ok_in),
		.req_q     (req_q),
		.out_free  (out_free),
		.ready     (s_tready),
		.clr_addr  (clr_addr),
		.ctl       (ctl)
	);

	logic [CRN_W-1:0] elem_rdata;
	logic             elem_we;

	assign elem_we = accept && (req_type == REQ_ELEM) && elem_ok_in;

	mwd_ram #(
		.WIDTH(CRN_W),
		.DEPTH(ELEM_COUNT_MAX),
		.AW   (EAW)
	) u_elem_ram (
		.clk  (clk),
		.we   (elem_we),
		.waddr(elem_addr),
		.wdata({corner_c, corner_b, corner_a}),
		.re   (ctl.elem_rd),
		.raddr(elem_addr_q),
		.rdata(elem_rdata)
	);

	node_t corner_src [CORNERS];
	node_t corner_sel;
	sign_t sgn_sel;
	logic  corner_sel_ok;

	always_comb begin
		for (int k = 0; k < CORNERS; k++) begin
			corner_src[k] = (req_q == REQ_QUERY) ? elem_rdata[k*NODE_W +: NODE_W] : corner_q[k];
		end
		case (ctl.step)
			2'd0: begin
				corner_sel = corner_src[0];
				sgn_sel    = sgn_q[0];
			end
			2'd1: begin
				corner_sel = corner_src[1];
				sgn_sel    = sgn_q[1];
			end
			default: begin
				corner_sel = corner_src[2];
				sgn_sel    = sgn_q[2];
			end
		endcase
	end

	logic [NAW+NODE_W-1:0] corner_ext;

	assign corner_ext    = (NAW + NODE_W)'(corner_sel);
	assign corner_sel_ok = 32'(corner_sel) < NODE_LIM;

	logic           node_ld_we;
	logic           mark_we;
	logic           node_we;
	logic [NAW-1:0] node_waddr;
	sign_t          node_wdata;
	sign_t          node_rdata;
	sign_t          sign_in;
	acc_t           acc;
	logic [FLAG_W-1:0] acc_flag;

	assign node_ld_we = accept && (req_type == REQ_NODE) && node_ok_in;
	assign mark_we    = ctl.mark_we && !acc.all_pos && corner_sel_ok;
	assign node_we    = ctl.clr_we || node_ld_we || mark_we;

	always_comb begin
		if (ctl.clr_we) begin
			node_waddr = clr_addr;
			node_wdata = '0;
		end else if (node_ld_we) begin
			node_waddr = node_ext[NAW-1:0];
			node_wdata = sign_of(head_now, head_before);
		end else begin
			node_waddr          = corner_ext[NAW-1:0];
			node_wdata          = sgn_sel;
			node_wdata[SB_MARK] = 1'b1;
		end
	end

	mwd_ram #(
		.WIDTH(SIGN_W),
		.DEPTH(NODE_COUNT_MAX),
		.AW   (NAW)
	) u_node_ram (
		.clk  (clk),
		.we   (node_we),
		.waddr(node_waddr),
		.wdata(node_wdata),
		.re   (ctl.node_rd),
		.raddr(corner_ext[NAW-1:0]),
		.rdata(node_rdata)
	);

	assign sign_in = ok_s1 ? node_rdata : '0;

	mwd_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (ctl.acc_clr),
		.step   (ctl.acc_step),
		.sign_in(sign_in),
		.acc    (acc),
		.flag   (acc_flag)
	);

	logic [1:0] sgn_idx;

	assign sgn_idx = ctl.step - 2'd1;

	always_ff @(posedge clk) begin
		if (accept) begin
			elem_addr_q <= elem_addr;
			corner_q[0] <= corner_a;
			corner_q[1] <= corner_b;
			corner_q[2] <= corner_c;
		end
		if (ctl.node_rd) begin
			ok_s1 <= corner_sel_ok;
		end
		if (ctl.acc_step) begin
			sgn_q[sgn_idx] <= sign_in;
		end
	end

	logic out_load;

	assign out_load = ctl.finish ||
		(accept && ((req_type == REQ_NODE) || (req_type == REQ_NONE)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q      <= REQ_NONE;
			elem_ok_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
			flag_q     <= FLAG_WET;
		end else begin
			if (accept) begin
				req_q     <= req_type;
				elem_ok_q <= elem_ok_in;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
				flag_q     <= (ctl.finish && (req_q == REQ_QUERY) && elem_ok_q) ?
					acc_flag : FLAG_WET;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_DW'(flag_q);

	a_node_write_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.clr_we, node_ld_we, mark_we}))
		else $error("Node table written by more than one source.");

	a_no_request_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clr_we |-> !s_tready)
		else $error("Request taken during the clearing pass.");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_tvalid || m_tready))
		else $error("Pending result overwritten.");

	a_step_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.acc_step |-> $past(ctl.node_rd))
		else $error("Sign step without a preceding node read.");

endmodule

>>> rtl/core/mwd_ram.sv
// ----------------------------------------------------------------------------
// mwd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mwd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/mwd_acc.sv
// ----------------------------------------------------------------------------
// mwd_acc
// Shared sign test unit: folds one corner's sign bits per step into the
// all-positive, any-marked and all-dry conditions and forms the flag.
// ----------------------------------------------------------------------------
module mwd_acc
	import mwd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clr,
	input  logic              step,
	input  sign_t             sign_in,
	output acc_t              acc,
	output logic [FLAG_W-1:0] flag
);

	acc_t acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '{all_pos: 1'b1, any_mark: 1'b0, all_dry: 1'b1};
		end else if (clr) begin
			acc_q <= '{all_pos: 1'b1, any_mark: 1'b0, all_dry: 1'b1};
		end else if (step) begin
			acc_q.all_pos  <= acc_q.all_pos && sign_in[SB_POS_NOW];
			acc_q.any_mark <= acc_q.any_mark || sign_in[SB_MARK];
			acc_q.all_dry  <= acc_q.all_dry && sign_in[SB_NEG_NOW] && sign_in[SB_NEG_PREV];
		end
	end

	always_comb begin
		if (acc_q.all_dry) begin
			flag = FLAG_DRY;
		end else if (acc_q.any_mark) begin
			flag = FLAG_NEAR;
		end else begin
			flag = FLAG_WET;
		end
	end

	assign acc = acc_q;

endmodule

>>> rtl/core/mwd_ctrl.sv
// ----------------------------------------------------------------------------
// mwd_ctrl
// Sequencer: clearing pass after reset, element fetch for queries, three
// corner reads, three mark writes for element loads and result hand-off.
// ----------------------------------------------------------------------------
module mwd_ctrl
	import mwd_pkg::*;
#(
	parameter int NODE_COUNT_MAX = NODE_COUNT_MAX_DEF,
	parameter int NAW            = (NODE_COUNT_MAX > 1) ? $clog2(NODE_COUNT_MAX) : 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  req_t           req_in,
	input  logic           elem_ok_in,
	input  req_t           req_q,
	input  logic           out_free,
	output logic           ready,
	output logic [NAW-1:0] clr_addr,
	output ctl_t           ctl
);

	localparam logic [NAW-1:0] CLR_LAST = NAW'(NODE_COUNT_MAX - 1);

	state_t         state_q, state_d;
	logic [1:0]     step_q, step_d;
	logic [NAW-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			step_q  <= '0;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		step_d  = '0;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (req_in)
						REQ_ELEM:  state_d = elem_ok_in ? ST_READ : ST_DONE;
						REQ_QUERY: state_d = elem_ok_in ? ST_ELEM : ST_DONE;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_ELEM: begin
				state_d = ST_READ;
			end
			ST_READ: begin
				step_d = step_q + 1'b1;
				if (step_q == 2'd3) begin
					step_d  = '0;
					state_d = (req_q == REQ_ELEM) ? ST_MARK : ST_DONE;
				end
			end
			ST_MARK: begin
				step_d = step_q + 1'b1;
				if (step_q == 2'd2) begin
					step_d  = '0;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl          = '0;
		ctl.step     = step_q;
		ctl.clr_we   = (state_q == ST_CLEAR);
		ctl.elem_rd  = (state_q == ST_ELEM);
		ctl.node_rd  = (state_q == ST_READ) && (step_q != 2'd3);
		ctl.acc_clr  = (state_q == ST_READ) && (step_q == 2'd0);
		ctl.acc_step = (state_q == ST_READ) && (step_q != 2'd0);
		ctl.mark_we  = (state_q == ST_MARK);
		ctl.finish   = (state_q == ST_DONE) && out_free;
	end

	assign ready    = (state_q == ST_IDLE) && out_free;
	assign clr_addr = clr_q;

endmodule
